FILE: rtl/vrot_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrot_pkg
// Shared constants for the 2-D vector rotator: CORDIC angle table, gain and
// fixed-point layout.
// ----------------------------------------------------------------------------
package vrot_pkg;

   localparam int COMPONENT_WIDTH_DEF = 16;
   localparam int ANGLE_WIDTH_DEF     = 16;

   localparam int GUARD_BITS = 16;
   localparam int ROT_STEPS  = 30;
   localparam int HEAD_BITS  = 3;

   // angle accumulator: 2^32 = one full turn, one extra bit for the fold
   localparam int TURN_BITS = 32;
   localparam int ACC_WIDTH = TURN_BITS + 1;

   localparam logic signed [ACC_WIDTH-1:0] ANGLE_QUARTER = 33'sh0_4000_0000;
   localparam logic signed [ACC_WIDTH-1:0] ANGLE_HALF    = 33'sh0_8000_0000;

   // gain compensation 1/1.6468 in Q0.32, magnitude split point
   localparam int              GAIN_WIDTH = 32;
   localparam logic [31:0]     GAIN_Q32   = 32'd2608131496;
   localparam int              SPLIT_BITS = 20;
   localparam int              ROUND_SHIFT = 12 + GUARD_BITS;

   localparam logic [31:0] ATAN_TABLE [32] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81,
      32'd41,        32'd20,        32'd10,        32'd5,
      32'd3,         32'd1,         32'd1,         32'd0
   };

endpackage

FILE: rtl/vector_rotate_2d.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_rotate_2d
// Rotates (x, y) by a binary angle with a pipelined, gain-compensated CORDIC.
//
// Input channel req_*: one item carries x, y (signed Q2.13) and the angle
// (signed, 2^(ANGLE_WIDTH-1) = pi). Result channel rsp_*: one item per input
// with the rotated x and y (signed Q4.13), in input order.
// Path from the req accept to rsp_tvalid: fold register loaded at accept,
// then 30 CORDIC cells, 3 gain stages, output register.
// Throughput: one item per cycle while the pipeline is not frozen,
// set by the chain of CORDIC cells, each doing one micro-rotation per cycle.
// When rsp_tready is low the finished item holds in the output register and
// one more is taken into a skid entry; req_tready then drops and the whole
// pipeline freezes until the skid empties. req_tready is a register output.
// Reset clears all valid flags; the pipeline comes up empty and ready.
// ----------------------------------------------------------------------------
module vector_rotate_2d import vrot_pkg::*; #(
   parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF,
   parameter int ANGLE_WIDTH     = ANGLE_WIDTH_DEF,
   localparam int IN_W  = ((2 * COMPONENT_WIDTH + ANGLE_WIDTH + 7) / 8) * 8,
   localparam int OUT_W = ((2 * (COMPONENT_WIDTH + 2) + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [IN_W-1:0]  req_tdata,  // x_in, y_in, turn_angle
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [OUT_W-1:0] rsp_tdata   // x_out, y_out
);

   localparam int CW = COMPONENT_WIDTH;
   localparam int AW = ANGLE_WIDTH;
   localparam int OW = CW + 2;
   localparam int XW = CW + GUARD_BITS + HEAD_BITS;
   localparam int ZSHIFT = TURN_BITS - AW;

   logic                        enable;
   logic signed [CW-1:0]        x_field, y_field;
   logic signed [AW-1:0]        a_field;
   logic signed [XW-1:0]        x_ext, y_ext, x_fold_in, y_fold_in;
   logic signed [ACC_WIDTH-1:0] z_ext, z_fold_in;

   logic                        fold_valid_ff;
   logic signed [XW-1:0]        x_fold_ff, y_fold_ff;
   logic signed [ACC_WIDTH-1:0] z_fold_ff;

   logic                        valid_pipe [ROT_STEPS+1];
   logic signed [XW-1:0]        x_pipe     [ROT_STEPS+1];
   logic signed [XW-1:0]        y_pipe     [ROT_STEPS+1];
   logic signed [ACC_WIDTH-1:0] z_pipe     [ROT_STEPS+1];

   logic [2:0]                  scale_valid_ff;
   logic signed [OW-1:0]        x_res, y_res;
   logic [OUT_W-1:0]            res_data;

   assign x_field = req_tdata[CW-1:0];
   assign y_field = req_tdata[2*CW-1:CW];
   assign a_field = req_tdata[2*CW+AW-1:2*CW];

   always_comb begin
      x_ext = XW'(x_field) <<< GUARD_BITS;
      y_ext = XW'(y_field) <<< GUARD_BITS;
      z_ext = ACC_WIDTH'(a_field) <<< ZSHIFT;
      if (z_ext > ANGLE_QUARTER) begin
         x_fold_in = -x_ext;
         y_fold_in = -y_ext;
         z_fold_in = z_ext - ANGLE_HALF;
      end else if (z_ext < -ANGLE_QUARTER) begin
         x_fold_in = -x_ext;
         y_fold_in = -y_ext;
         z_fold_in = z_ext + ANGLE_HALF;
      end else begin
         x_fold_in = x_ext;
         y_fold_in = y_ext;
         z_fold_in = z_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_valid_ff <= 1'b0;
      end else if (enable) begin
         fold_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_fold_ff <= x_fold_in;
         y_fold_ff <= y_fold_in;
         z_fold_ff <= z_fold_in;
      end
   end

   assign valid_pipe[0] = fold_valid_ff;
   assign x_pipe[0]     = x_fold_ff;
   assign y_pipe[0]     = y_fold_ff;
   assign z_pipe[0]     = z_fold_ff;

   for (genvar i = 0; i < ROT_STEPS; i++) begin : g_cell
      vrot_cell #(
         .XW   (XW),
         .STEP (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .valid_in  (valid_pipe[i]),
         .x_in      (x_pipe[i]),
         .y_in      (y_pipe[i]),
         .z_in      (z_pipe[i]),
         .valid_out (valid_pipe[i+1]),
         .x_out     (x_pipe[i+1]),
         .y_out     (y_pipe[i+1]),
         .z_out     (z_pipe[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_valid_ff <= '0;
      end else if (enable) begin
         scale_valid_ff <= {scale_valid_ff[1:0], valid_pipe[ROT_STEPS]};
      end
   end

   vrot_scale #(.CW(CW), .XW(XW)) u_scale_x (
      .clock     (clock),
      .enable    (enable),
      .value_in  (x_pipe[ROT_STEPS]),
      .value_out (x_res)
   );

   vrot_scale #(.CW(CW), .XW(XW)) u_scale_y (
      .clock     (clock),
      .enable    (enable),
      .value_in  (y_pipe[ROT_STEPS]),
      .value_out (y_res)
   );

   assign res_data = OUT_W'({y_res, x_res});

   vrot_outbuf #(.W(OUT_W)) u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (scale_valid_ff[2]),
      .in_data   (res_data),
      .in_ready  (enable),
      .out_valid (rsp_tvalid),
      .out_data  (rsp_tdata),
      .out_ready (rsp_tready)
   );

   assign req_tready = enable;

endmodule

FILE: rtl/vrot_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrot_cell
// One CORDIC micro-rotation in rotation mode, registered.
// ----------------------------------------------------------------------------
module vrot_cell import vrot_pkg::*; #(
   parameter int XW   = 35,
   parameter int STEP = 0
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        enable,
   input  logic                        valid_in,
   input  logic signed [XW-1:0]        x_in,
   input  logic signed [XW-1:0]        y_in,
   input  logic signed [ACC_WIDTH-1:0] z_in,
   output logic                        valid_out,
   output logic signed [XW-1:0]        x_out,
   output logic signed [XW-1:0]        y_out,
   output logic signed [ACC_WIDTH-1:0] z_out
);

   localparam logic signed [ACC_WIDTH-1:0] ATAN_STEP = {1'b0, ATAN_TABLE[STEP]};

   logic                        valid_ff;
   logic signed [XW-1:0]        x_ff, y_ff, x_nx_in, y_nx_in;
   logic signed [ACC_WIDTH-1:0] z_ff, z_nx_in;
   logic signed [XW-1:0]        dx, dy;

   always_comb begin
      dx = y_in >>> STEP;
      dy = x_in >>> STEP;
      if (!z_in[ACC_WIDTH-1]) begin
         x_nx_in = x_in - dx;
         y_nx_in = y_in + dy;
         z_nx_in = z_in - ATAN_STEP;
      end else begin
         x_nx_in = x_in + dx;
         y_nx_in = y_in - dy;
         z_nx_in = z_in + ATAN_STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff <= x_nx_in;
         y_ff <= y_nx_in;
         z_ff <= z_nx_in;
      end
   end

   assign valid_out = valid_ff;
   assign x_out     = x_ff;
   assign y_out     = y_ff;
   assign z_out     = z_ff;

endmodule

FILE: rtl/vrot_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrot_scale
// Gain compensation of one component: magnitude, split multiply by K,
// sum, then round half away from zero, restore sign and saturate.
// ----------------------------------------------------------------------------
module vrot_scale import vrot_pkg::*; #(
   parameter int CW = 16,
   parameter int XW = 35
) (
   input  logic                clock,
   input  logic                enable,
   input  logic signed [XW-1:0] value_in,
   output logic signed [CW+1:0] value_out
);

   localparam int OW   = CW + 2;
   localparam int HIW  = XW - SPLIT_BITS;
   localparam int HKW  = HIW + GAIN_WIDTH;
   localparam int LKW  = SPLIT_BITS + GAIN_WIDTH;
   localparam int PW   = HKW + 1;
   localparam int SW   = PW + 1;
   localparam int RW   = SW - ROUND_SHIFT;
   localparam logic [SW-1:0] ROUND_BIAS = SW'(1) << (ROUND_SHIFT - 1);
   localparam logic [RW-1:0] LIMIT      = RW'(1) << (CW + 1);

   logic            neg1_ff, neg2_ff, neg3_ff;
   logic [XW-1:0]   mag_ff, mag_in;
   logic [HKW-1:0]  hi_k_ff, hi_k_in;
   logic [LKW-1:0]  lo_k_ff, lo_k_in;
   logic [PW-1:0]   p_ff, p_in;
   logic [SW-1:0]   rnd;
   logic [RW-1:0]   r;

   always_comb begin
      mag_in  = value_in[XW-1] ? XW'(-value_in) : XW'(value_in);
      hi_k_in = HKW'(mag_ff[XW-1:SPLIT_BITS]) * HKW'(GAIN_Q32);
      lo_k_in = LKW'(mag_ff[SPLIT_BITS-1:0]) * LKW'(GAIN_Q32);
      p_in    = PW'(hi_k_ff) + PW'(lo_k_ff >> SPLIT_BITS);
      rnd     = SW'(p_ff) + ROUND_BIAS;
      r       = rnd[SW-1:ROUND_SHIFT];
      if (r >= LIMIT) begin
         value_out = neg3_ff ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
      end else begin
         value_out = neg3_ff ? -$signed(r[OW-1:0]) : $signed(r[OW-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         neg1_ff <= value_in[XW-1];
         mag_ff  <= mag_in;
         neg2_ff <= neg1_ff;
         hi_k_ff <= hi_k_in;
         lo_k_ff <= lo_k_in;
         neg3_ff <= neg2_ff;
         p_ff    <= p_in;
      end
   end

endmodule

FILE: rtl/vrot_outbuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrot_outbuf
// Output register with skid entry; upstream ready is registered.
// ----------------------------------------------------------------------------
module vrot_outbuf #(
   parameter int W = 40
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  logic [W-1:0] in_data,
   output logic         in_ready,
   output logic         out_valid,
   output logic [W-1:0] out_data,
   input  logic         out_ready
);

   logic         out_valid_ff, out_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   logic [W-1:0] out_data_ff, out_data_in;
   logic [W-1:0] skid_data_ff, skid_data_in;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || out_ready) begin
         out_valid_in  = skid_valid_ff || in_valid;
         out_data_in   = skid_valid_ff ? skid_data_ff : in_data;
         skid_valid_in = 1'b0;
      end else if (in_valid && !skid_valid_ff) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule
